FILE: hdl/pcsv_pkg.sv
// pcsv_pkg: shared types and constants for the png chunk stream validator
// depends on nothing; used by every file of the block
package pcsv_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [9:0]  offset;
    logic [3:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [2:0]  col_type;
    logic [2:0]  channels;
    logic [8:0]  palette_count;
    logic [31:0] data_total;
  } out_word_t;

  localparam logic [1:0] KIND_DAT = 2'd0;
  localparam logic [1:0] KIND_PAL = 2'd1;
  localparam logic [1:0] KIND_TRN = 2'd2;
  localparam logic [1:0] KIND_REP = 2'd3;

  localparam logic [3:0] ST_OK   = 4'd0;
  localparam logic [3:0] ST_SIG  = 4'd1;
  localparam logic [3:0] ST_TRUN = 4'd2;
  localparam logic [3:0] ST_CRC  = 4'd3;
  localparam logic [3:0] ST_HDR  = 4'd4;
  localparam logic [3:0] ST_PAL  = 4'd5;
  localparam logic [3:0] ST_TRN  = 4'd6;
  localparam logic [3:0] ST_DAT  = 4'd7;
  localparam logic [3:0] ST_END  = 4'd8;
  localparam logic [3:0] ST_MISS = 4'd9;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic [31:0] T_IHDR = 32'h49484452;
  localparam logic [31:0] T_PLTE = 32'h504C5445;
  localparam logic [31:0] T_TRNS = 32'h74524E53;
  localparam logic [31:0] T_IDAT = 32'h49444154;
  localparam logic [31:0] T_IEND = 32'h49454E44;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // one parsed word handed from the front to the back
  typedef struct packed {
    logic        last;
    logic        fwd;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [9:0]  offset;
    logic [3:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [2:0]  col_type;
    logic [2:0]  channels;
    logic [8:0]  palette_count;
    logic [31:0] data_total;
  } job_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4E;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0D;
      3'd5: r = 8'h0A;
      3'd6: r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
    end
    return x;
  endfunction

endpackage

FILE: hdl/pcsv_front.sv
// pcsv_front: byte parser, crc and chunk rule checks; emits a job for each forwarded byte and for the last word
// depends on pcsv_pkg
module pcsv_front #(
  parameter int PALETTE_BYTES = 768
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcsv_pkg::in_word_t in_data,
  output logic              job_valid,
  output pcsv_pkg::job_t    job,
  input  logic              job_room
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt, len_r, len_nxt, type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt, crcv_r, crcv_nxt;
  logic [31:0] pw_r, pw_nxt, ph_r, ph_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic        pbad_r, pbad_nxt;
  logic [31:0] iw_r, iw_nxt, ih_r, ih_nxt, db_r, db_nxt;
  logic [2:0]  ic_r, ic_nxt, ich_r, ich_nxt, seen_r, seen_nxt;
  logic [8:0]  pe_r, pe_nxt;
  logic [3:0]  err_r, err_nxt;

  logic        acc;
  logic [7:0]  b;
  logic [31:0] crcv_full;
  logic [32:0] db_sum;
  logic [2:0]  ch;
  logic        bad, hdr;
  logic [3:0]  st;
  // length / 3 for palette lengths; exact below 2^16
  logic [31:0] div3;

  assign in_ready = job_room;
  assign acc = in_valid && in_ready;
  assign b = in_data.in_byte;
  assign crcv_full = {crcv_r[23:0], b};
  assign db_sum = {1'b0, db_r} + {1'b0, len_r};
  assign hdr = seen_r[0];
  assign div3 = ({16'd0, len_r[15:0]} * 32'd43691) >> 17;

  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; len_nxt = len_r; type_nxt = type_r;
    crc_nxt = crc_r; crcv_nxt = crcv_r; pw_nxt = pw_r; ph_nxt = ph_r; pc_nxt = pc_r;
    pbad_nxt = pbad_r; iw_nxt = iw_r; ih_nxt = ih_r; ic_nxt = ic_r; ich_nxt = ich_r;
    pe_nxt = pe_r; db_nxt = db_r; seen_nxt = seen_r; err_nxt = err_r;
    job = '0;
    ch = 3'd0;
    bad = 1'b0;
    st = pcsv_pkg::ST_OK;
    if (err_r == pcsv_pkg::ST_OK) begin
      case (phase_r)
        pcsv_pkg::PH_SIG: begin
          if (b != pcsv_pkg::sig_byte(cnt_r[2:0])) begin
            err_nxt = pcsv_pkg::ST_SIG;
          end else if (cnt_r[2:0] == 3'd7) begin
            phase_nxt = pcsv_pkg::PH_LEN; cnt_nxt = '0; len_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        pcsv_pkg::PH_LEN: begin
          len_nxt = {len_r[23:0], b};
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r[1:0] == 2'd3) begin
            phase_nxt = pcsv_pkg::PH_TYPE; cnt_nxt = '0;
            crc_nxt = pcsv_pkg::CRC_INIT; type_nxt = '0;
          end
        end
        pcsv_pkg::PH_TYPE: begin
          type_nxt = {type_r[23:0], b};
          crc_nxt = pcsv_pkg::crc_byte(crc_r, b);
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0; crcv_nxt = '0; pw_nxt = '0; ph_nxt = '0; pc_nxt = '0;
            pbad_nxt = 1'b0;
            phase_nxt = (len_r == 32'd0) ? pcsv_pkg::PH_CRC : pcsv_pkg::PH_DATA;
          end
        end
        pcsv_pkg::PH_DATA: begin
          crc_nxt = pcsv_pkg::crc_byte(crc_r, b);
          if (type_r == pcsv_pkg::T_IHDR) begin
            if (cnt_r < 32'd4) pw_nxt = {pw_r[23:0], b};
            else if (cnt_r < 32'd8) ph_nxt = {ph_r[23:0], b};
            else if (cnt_r == 32'd8) begin
              if (b != 8'd8) pbad_nxt = 1'b1;
            end else if (cnt_r == 32'd9) pc_nxt = b;
            else if (cnt_r < 32'd13) begin
              if (b != 8'd0) pbad_nxt = 1'b1;
            end
          end else if (type_r == pcsv_pkg::T_IDAT) begin
            job.fwd = 1'b1; job.kind = pcsv_pkg::KIND_DAT;
          end else if (type_r == pcsv_pkg::T_PLTE) begin
            if (cnt_r < 32'(PALETTE_BYTES)) begin
              job.fwd = 1'b1; job.kind = pcsv_pkg::KIND_PAL; job.offset = cnt_r[9:0];
            end
          end else if (type_r == pcsv_pkg::T_TRNS) begin
            if (cnt_r < 32'd256) begin
              job.fwd = 1'b1; job.kind = pcsv_pkg::KIND_TRN; job.offset = cnt_r[9:0];
            end
          end
          job.value = b;
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt == len_r) begin
            phase_nxt = pcsv_pkg::PH_CRC; cnt_nxt = '0;
          end
        end
        pcsv_pkg::PH_CRC: begin
          crcv_nxt = crcv_full;
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r[1:0] == 2'd3) begin
            phase_nxt = pcsv_pkg::PH_LEN; cnt_nxt = '0; len_nxt = '0;
            if (crcv_full != ~crc_r) begin
              err_nxt = pcsv_pkg::ST_CRC; phase_nxt = phase_r; cnt_nxt = cnt_r + 32'd1;
              len_nxt = len_r;
            end else if (type_r == pcsv_pkg::T_IHDR) begin
              bad = hdr || len_r != 32'd13 || pbad_r || pw_r == 32'd0 || ph_r == 32'd0;
              case (pc_r)
                8'd0: ch = 3'd1;
                8'd2: ch = 3'd3;
                8'd3: ch = 3'd1;
                8'd4: ch = 3'd2;
                8'd6: ch = 3'd4;
                default: bad = 1'b1;
              endcase
              if (bad) begin
                err_nxt = pcsv_pkg::ST_HDR; phase_nxt = phase_r; len_nxt = len_r;
              end else begin
                iw_nxt = pw_r; ih_nxt = ph_r; ic_nxt = pc_r[2:0]; ich_nxt = ch;
                seen_nxt[0] = 1'b1;
              end
            end else if (type_r == pcsv_pkg::T_PLTE) begin
              if (!hdr || ic_r != 3'd3 || len_r == 32'd0 || len_r > 32'(PALETTE_BYTES)
                  || (div3 * 32'd3) != len_r) begin
                err_nxt = pcsv_pkg::ST_PAL; phase_nxt = phase_r; len_nxt = len_r;
              end else begin
                pe_nxt = div3[8:0];
              end
            end else if (type_r == pcsv_pkg::T_TRNS) begin
              if (!(hdr && ((ic_r == 3'd3 && len_r <= 32'd256) ||
                            (ic_r == 3'd0 && len_r == 32'd2) ||
                            (ic_r == 3'd2 && len_r == 32'd6)))) begin
                err_nxt = pcsv_pkg::ST_TRN; phase_nxt = phase_r; len_nxt = len_r;
              end
            end else if (type_r == pcsv_pkg::T_IDAT) begin
              if (!hdr || len_r == 32'd0 || db_sum[32]) begin
                err_nxt = pcsv_pkg::ST_DAT; phase_nxt = phase_r; len_nxt = len_r;
              end else begin
                db_nxt = db_sum[31:0]; seen_nxt[1] = 1'b1;
              end
            end else if (type_r == pcsv_pkg::T_IEND) begin
              if (len_r != 32'd0 || !hdr || !seen_r[1]) begin
                err_nxt = pcsv_pkg::ST_END; phase_nxt = phase_r; len_nxt = len_r;
              end else begin
                seen_nxt[2] = 1'b1; phase_nxt = pcsv_pkg::PH_DONE; len_nxt = len_r;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // final report reads the updated state
    if (err_nxt != pcsv_pkg::ST_OK) st = err_nxt;
    else if (phase_nxt == pcsv_pkg::PH_DONE)
      st = (ic_nxt == 3'd3 && pe_nxt == 9'd0) ? pcsv_pkg::ST_MISS : pcsv_pkg::ST_OK;
    else if (phase_nxt == pcsv_pkg::PH_SIG) st = pcsv_pkg::ST_SIG;
    else if (phase_nxt == pcsv_pkg::PH_LEN && cnt_nxt == 32'd0) st = pcsv_pkg::ST_MISS;
    else st = pcsv_pkg::ST_TRUN;
    job.last = in_data.in_last;
    if (in_data.in_last) begin
      job.fwd = 1'b0; job.kind = pcsv_pkg::KIND_REP; job.value = '0; job.offset = '0;
      job.status = st; job.width = iw_nxt; job.height = ih_nxt; job.col_type = ic_nxt;
      job.channels = ich_nxt; job.palette_count = pe_nxt; job.data_total = db_nxt;
    end
  end

  assign job_valid = acc && (in_data.in_last || job.fwd);

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_data.in_last)) begin
      phase_r <= pcsv_pkg::PH_SIG; cnt_r <= '0; len_r <= '0; type_r <= '0;
      crc_r <= pcsv_pkg::CRC_INIT; crcv_r <= '0; pw_r <= '0; ph_r <= '0; pc_r <= '0;
      pbad_r <= 1'b0; iw_r <= '0; ih_r <= '0; ic_r <= '0; ich_r <= '0; pe_r <= '0;
      db_r <= '0; seen_r <= '0; err_r <= pcsv_pkg::ST_OK;
    end else if (acc) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; len_r <= len_nxt; type_r <= type_nxt;
      crc_r <= crc_nxt; crcv_r <= crcv_nxt; pw_r <= pw_nxt; ph_r <= ph_nxt; pc_r <= pc_nxt;
      pbad_r <= pbad_nxt; iw_r <= iw_nxt; ih_r <= ih_nxt; ic_r <= ic_nxt; ich_r <= ich_nxt;
      pe_r <= pe_nxt; db_r <= db_nxt; seen_r <= seen_nxt; err_r <= err_nxt;
    end
  end

endmodule

FILE: hdl/pcsv_queue.sv
// pcsv_queue: small job fifo between front and back
// depends on pcsv_pkg
module pcsv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  input  pcsv_pkg::job_t wr_job,
  output logic           room,
  output logic           rd_valid,
  output pcsv_pkg::job_t rd_job,
  input  logic           rd_ready
);

  pcsv_pkg::job_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic wr, rd;

  assign room = (cnt_r < 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && room;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

endmodule

FILE: hdl/pcsv_back.sv
// pcsv_back: output register stage, turns jobs into result words
// depends on pcsv_pkg
module pcsv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  pcsv_pkg::job_t     job,
  output logic               job_ready,
  output logic               out_valid,
  output pcsv_pkg::out_word_t out_data,
  input  logic               out_ready
);

  logic valid_r;
  pcsv_pkg::out_word_t data_r;

  assign job_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (job_ready) valid_r <= job_valid;
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      data_r <= '{kind: job.kind, value: job.value, offset: job.offset, status: job.status,
                  width: job.width, height: job.height, col_type: job.col_type,
                  channels: job.channels, palette_count: job.palette_count,
                  data_total: job.data_total};
    end
  end

endmodule

FILE: hdl/png_chunk_stream_validator_unit.sv
// png_chunk_stream_validator_unit: top level of the png chunk stream validator
// depends on pcsv_pkg, pcsv_front, pcsv_queue, pcsv_back
//
// Takes a png file one byte per word and returns one word a cycle at best:
// every accepted byte is taken by the parser front, whose crc update
// and chunk checks are a single step; forwarded image, palette and
// transparency bytes and the final report pass a four-entry queue and an
// output register, and in_ready drops only when the queue is full. The
// report comes on the word marked last and the parser then returns to its
// reset state for the next file.
module png_chunk_stream_validator_unit #(
  parameter int PALETTE_BYTES = 768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcsv_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcsv_pkg::out_word_t out_data
);

  // front to queue
  logic           f_valid, q_room;
  pcsv_pkg::job_t f_job;
  // queue to back
  logic           q_valid, b_ready;
  pcsv_pkg::job_t q_job;

  pcsv_front #(.PALETTE_BYTES(PALETTE_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .job_valid(f_valid), .job(f_job), .job_room(q_room)
  );

  pcsv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_job(f_job), .room(q_room),
    .rd_valid(q_valid), .rd_job(q_job), .rd_ready(b_ready)
  );

  pcsv_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_job), .job_ready(b_ready),
    .out_valid(out_valid), .out_data(out_data), .out_ready(out_ready)
  );

endmodule

FILE: hdl/pcsv_checker.sv
// pcsv_checker: port-level assertions for the validator
// depends on pcsv_pkg and png_chunk_stream_validator_unit
module pcsv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input pcsv_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input pcsv_pkg::out_word_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // forwarded words carry no status
  a_fwd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != pcsv_pkg::KIND_REP |-> out_data.status == pcsv_pkg::ST_OK)
    else $error("status in forwarded word");

  // image data words carry no offset
  a_dat_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == pcsv_pkg::KIND_DAT |-> out_data.offset == 10'd0)
    else $error("offset in image data word");

  // no output straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind png_chunk_stream_validator_unit pcsv_checker u_pcsv_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
